### src/csr_pkg.sv
// csr_pkg: beat types, status codes and register indexes for the sparse row store.
// No dependencies; imported by every module in src.
package csr_pkg;

    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 13;
    localparam int ROWS_W   = 9;
    localparam int CFG_W    = 9;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_RANGE    = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    localparam logic KIND_APPEND = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [VALUE_W-1:0] elem_value;
        logic [INDEX_W-1:0] row_index;
        logic [INDEX_W-1:0] col_index;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        t_status            status;
        logic [COUNT_W-1:0] nonzero_count;
        logic [ROWS_W-1:0]  rows_filled;
    } t_out_item;

endpackage

### src/csr_nz_mem.sv
// csr_nz_mem: value and column memories for nonzero elements.
// One write port and one registered read port, each with its own address. Uses csr_pkg.
module csr_nz_mem
    import csr_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic [VALUE_W-1:0] i_wvalue,
    input  logic [INDEX_W-1:0] i_wcol,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output logic [VALUE_W-1:0] o_rvalue,
    output logic [INDEX_W-1:0] o_rcol
);

    logic [VALUE_W-1:0] r_value_mem [DEPTH];
    logic [INDEX_W-1:0] r_col_mem   [DEPTH];
    logic [VALUE_W-1:0] r_rvalue;
    logic [INDEX_W-1:0] r_rcol;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_value_mem[i_waddr] <= i_wvalue;
            r_col_mem[i_waddr]   <= i_wcol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rvalue <= r_value_mem[i_raddr];
            r_rcol   <= r_col_mem[i_raddr];
        end
    end

    assign o_rvalue = r_rvalue;
    assign o_rcol   = r_rcol;

endmodule

### src/csr_rp_mem.sv
// csr_rp_mem: row-end pointer memory, one entry per completed row.
// One write port, one registered read port. Uses csr_pkg.
module csr_rp_mem
    import csr_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 13
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/csr_engine.sv
// csr_engine: append/read sequencer, counters, binary search and output register.
// Drives csr_nz_mem and csr_rp_mem ports. Uses csr_pkg.
module csr_engine
    import csr_pkg::*;
#(
    parameter int MAX_ROWS     = 256,
    parameter int MAX_COLS     = 256,
    parameter int MAX_NONZEROS = 4096,
    parameter int ROW_AW       = 8,
    parameter int NZ_AW        = 12,
    parameter int CNT_W        = 13
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CFG_W-1:0]   i_num_rows,
    input  logic [CFG_W-1:0]   i_num_cols,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out,
    // nonzero store
    output logic               o_nz_we,
    output logic [NZ_AW-1:0]   o_nz_waddr,
    output logic [VALUE_W-1:0] o_nz_wvalue,
    output logic [INDEX_W-1:0] o_nz_wcol,
    output logic               o_nz_re,
    output logic [NZ_AW-1:0]   o_nz_raddr,
    input  logic [VALUE_W-1:0] i_nz_rvalue,
    input  logic [INDEX_W-1:0] i_nz_rcol,
    // row-end store
    output logic               o_rp_we,
    output logic [ROW_AW-1:0]  o_rp_waddr,
    output logic [CNT_W-1:0]   o_rp_wdata,
    output logic               o_rp_re,
    output logic [ROW_AW-1:0]  o_rp_raddr,
    input  logic [CNT_W-1:0]   i_rp_rdata
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RPLO = 5'b00010,
        S_RPHI = 5'b00100,
        S_SRCH = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state              r_state,   n_state;
    logic [ROWS_W-1:0]   r_row_cnt, n_row_cnt;
    logic [CNT_W-1:0]    r_stored,  n_stored;
    logic [CFG_W-1:0]    r_col_pos, n_col_pos;
    logic [INDEX_W-1:0]  r_row,     n_row;
    logic [INDEX_W-1:0]  r_col,     n_col;
    logic [CNT_W-1:0]    r_lo,      n_lo;
    logic [CNT_W-1:0]    r_hi,      n_hi;
    logic [CNT_W-1:0]    r_mid,     n_mid;
    logic [VALUE_W-1:0]  r_res_val, n_res_val;
    t_status             r_res_st,  n_res_st;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out,     n_out;

    logic [CFG_W-1:0]    w_eff_rows;
    logic [CFG_W-1:0]    w_eff_cols;
    logic                w_accept;

    assign w_eff_rows = (32'(i_num_rows) > 32'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : i_num_rows;
    assign w_eff_cols = (32'(i_num_cols) > 32'(MAX_COLS)) ? CFG_W'(MAX_COLS) : i_num_cols;
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        logic [CNT_W-1:0] v_stored;
        logic [CFG_W-1:0] v_pos1;
        logic [CNT_W:0]   v_sum;
        logic [CNT_W-1:0] v_lo;
        logic [CNT_W-1:0] v_hi;
        logic [CNT_W-1:0] v_mid;

        n_state     = r_state;
        n_row_cnt   = r_row_cnt;
        n_stored    = r_stored;
        n_col_pos   = r_col_pos;
        n_row       = r_row;
        n_col       = r_col;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_res_val   = r_res_val;
        n_res_st    = r_res_st;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        o_nz_we     = 1'b0;
        o_nz_waddr  = NZ_AW'(r_stored);
        o_nz_wvalue = i_in.elem_value;
        o_nz_wcol   = r_col_pos[INDEX_W-1:0];
        o_nz_re     = 1'b0;
        o_nz_raddr  = NZ_AW'(r_mid);
        o_rp_we     = 1'b0;
        o_rp_waddr  = ROW_AW'(r_row_cnt);
        o_rp_wdata  = r_stored;
        o_rp_re     = 1'b0;
        o_rp_raddr  = ROW_AW'(r_row);

        v_stored = r_stored;
        v_pos1   = r_col_pos + CFG_W'(1);
        v_sum    = '0;
        v_lo     = r_lo;
        v_hi     = r_hi;
        v_mid    = r_mid;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_row     = i_in.row_index;
                    n_col     = i_in.col_index;
                    n_res_val = '0;
                    n_res_st  = ST_OK;
                    n_state   = S_DONE;
                    if (i_in.kind == KIND_APPEND) begin
                        if (r_row_cnt >= w_eff_rows) begin
                            n_res_st = ST_FULL;
                        end else if (w_eff_cols == '0) begin
                            // empty row completes at once
                            o_rp_we   = 1'b1;
                            n_row_cnt = r_row_cnt + ROWS_W'(1);
                            n_col_pos = '0;
                        end else begin
                            if (i_in.elem_value[VALUE_W-2:0] != '0) begin
                                if (r_stored == CNT_W'(MAX_NONZEROS)) begin
                                    n_res_st = ST_OVERFLOW;
                                end else begin
                                    o_nz_we  = 1'b1;
                                    v_stored = r_stored + CNT_W'(1);
                                end
                            end
                            n_stored = v_stored;
                            if (v_pos1 < w_eff_cols) begin
                                n_col_pos = v_pos1;
                            end else begin
                                o_rp_we    = 1'b1;
                                o_rp_wdata = v_stored;
                                n_row_cnt  = r_row_cnt + ROWS_W'(1);
                                n_col_pos  = '0;
                            end
                        end
                    end else begin
                        if ({1'b0, i_in.row_index} >= w_eff_rows ||
                            {1'b0, i_in.col_index} >= w_eff_cols) begin
                            n_res_st = ST_RANGE;
                        end else if ({1'b0, i_in.row_index} < r_row_cnt) begin
                            // fetch previous row end first (row zero starts at zero)
                            o_rp_re    = 1'b1;
                            o_rp_raddr = (i_in.row_index == '0) ? '0 :
                                         ROW_AW'(i_in.row_index - INDEX_W'(1));
                            n_state    = S_RPLO;
                        end
                    end
                end
            end
            S_RPLO: begin
                n_lo    = (r_row == '0) ? '0 : i_rp_rdata;
                o_rp_re = 1'b1;
                n_state = S_RPHI;
            end
            S_RPHI: begin
                v_hi  = i_rp_rdata;
                v_sum = {1'b0, r_lo} + {1'b0, v_hi};
                v_mid = v_sum[CNT_W:1];
                n_hi  = v_hi;
                n_mid = v_mid;
                if (r_lo < v_hi) begin
                    o_nz_re    = 1'b1;
                    o_nz_raddr = NZ_AW'(v_mid);
                    n_state    = S_SRCH;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SRCH: begin
                if (i_nz_rcol == r_col) begin
                    n_res_val = i_nz_rvalue;
                    n_state   = S_DONE;
                end else begin
                    if (i_nz_rcol > r_col) begin
                        v_hi = r_mid;
                    end else begin
                        v_lo = r_mid + CNT_W'(1);
                    end
                    v_sum = {1'b0, v_lo} + {1'b0, v_hi};
                    v_mid = v_sum[CNT_W:1];
                    n_lo  = v_lo;
                    n_hi  = v_hi;
                    n_mid = v_mid;
                    if (v_lo < v_hi) begin
                        o_nz_re    = 1'b1;
                        o_nz_raddr = NZ_AW'(v_mid);
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid         = 1'b1;
                    n_out.read_value    = r_res_val;
                    n_out.status        = r_res_st;
                    n_out.nonzero_count = COUNT_W'(r_stored);
                    n_out.rows_filled   = r_row_cnt;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_cnt   <= '0;
            r_stored    <= '0;
            r_col_pos   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_cnt   <= n_row_cnt;
            r_stored    <= n_stored;
            r_col_pos   <= n_col_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row     <= n_row;
        r_col     <= n_col;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
        r_out     <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_stored_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= CNT_W'(MAX_NONZEROS))
        else $error("nonzero count above store depth");

    a_search_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH) |-> (r_lo < r_hi && r_mid >= r_lo && r_mid < r_hi))
        else $error("search window empty or mid outside it");

    a_rows_only_on_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_row_cnt) && $stable(r_stored))
        else $error("counters moved without an input beat");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("input ready right after a beat");

endmodule

### src/csr_sparse_row_store.sv
// csr_sparse_row_store: top level; APB config registers, engine and the two memories.
// Depends on csr_pkg, csr_engine, csr_nz_mem, csr_rp_mem.
//
//  port group     dir   handshake                   payload
//  input beat     in    i_in_valid / o_in_ready     t_in_item  i_in
//  result beat    out   o_out_valid / i_out_ready   t_out_item o_out
//  config         in    psel, penable, pwrite       paddr, pwdata -> prdata
//
// One item in flight. Appends, out-of-range reads and incomplete-row reads: S_DONE, result load.
// Read of a completed row: row-end reads (S_RPLO, S_RPHI), then k binary search probes (0 for
// an empty row, at most log2 of the row's nonzeros + 1) in S_SRCH, one probe per cycle through
// the registered value/column memory read port, then S_DONE and the result register load.
// Reset clears counters and control only; the memories hold nothing meaningful until written.
// A stalled result holds in the output register; the engine waits in its final state.
module csr_sparse_row_store
    import csr_pkg::*;
#(
    parameter int MAX_ROWS     = 256,
    parameter int MAX_COLS     = 256,
    parameter int MAX_NONZEROS = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int NZ_AW  = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
    localparam int CNT_W  = $clog2(MAX_NONZEROS + 1);

    logic [CFG_W-1:0]   r_num_rows;
    logic [CFG_W-1:0]   r_num_cols;

    logic               w_nz_we;
    logic [NZ_AW-1:0]   w_nz_waddr;
    logic [VALUE_W-1:0] w_nz_wvalue;
    logic [INDEX_W-1:0] w_nz_wcol;
    logic               w_nz_re;
    logic [NZ_AW-1:0]   w_nz_raddr;
    logic [VALUE_W-1:0] w_nz_rvalue;
    logic [INDEX_W-1:0] w_nz_rcol;
    logic               w_rp_we;
    logic [ROW_AW-1:0]  w_rp_waddr;
    logic [CNT_W-1:0]   w_rp_wdata;
    logic               w_rp_re;
    logic [ROW_AW-1:0]  w_rp_raddr;
    logic [CNT_W-1:0]   w_rp_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= '0;
            r_num_cols <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_NUM_ROWS: r_num_rows <= pwdata[CFG_W-1:0];
                REG_NUM_COLS: r_num_cols <= pwdata[CFG_W-1:0];
                default:      r_num_rows <= r_num_rows;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_NUM_ROWS: prdata = APB_DW'(r_num_rows);
            REG_NUM_COLS: prdata = APB_DW'(r_num_cols);
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    csr_engine #(
        .MAX_ROWS     (MAX_ROWS),
        .MAX_COLS     (MAX_COLS),
        .MAX_NONZEROS (MAX_NONZEROS),
        .ROW_AW       (ROW_AW),
        .NZ_AW        (NZ_AW),
        .CNT_W        (CNT_W)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_num_rows  (r_num_rows),
        .i_num_cols  (r_num_cols),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_nz_we     (w_nz_we),
        .o_nz_waddr  (w_nz_waddr),
        .o_nz_wvalue (w_nz_wvalue),
        .o_nz_wcol   (w_nz_wcol),
        .o_nz_re     (w_nz_re),
        .o_nz_raddr  (w_nz_raddr),
        .i_nz_rvalue (w_nz_rvalue),
        .i_nz_rcol   (w_nz_rcol),
        .o_rp_we     (w_rp_we),
        .o_rp_waddr  (w_rp_waddr),
        .o_rp_wdata  (w_rp_wdata),
        .o_rp_re     (w_rp_re),
        .o_rp_raddr  (w_rp_raddr),
        .i_rp_rdata  (w_rp_rdata)
    );

    csr_nz_mem #(
        .DEPTH (MAX_NONZEROS),
        .AW    (NZ_AW)
    ) u_nz_mem (
        .i_clk    (i_clk),
        .i_we     (w_nz_we),
        .i_waddr  (w_nz_waddr),
        .i_wvalue (w_nz_wvalue),
        .i_wcol   (w_nz_wcol),
        .i_re     (w_nz_re),
        .i_raddr  (w_nz_raddr),
        .o_rvalue (w_nz_rvalue),
        .o_rcol   (w_nz_rcol)
    );

    csr_rp_mem #(
        .DEPTH (MAX_ROWS),
        .AW    (ROW_AW),
        .DW    (CNT_W)
    ) u_rp_mem (
        .i_clk   (i_clk),
        .i_we    (w_rp_we),
        .i_waddr (w_rp_waddr),
        .i_wdata (w_rp_wdata),
        .i_re    (w_rp_re),
        .i_raddr (w_rp_raddr),
        .o_rdata (w_rp_rdata)
    );

endmodule

### tb/sv/csr_sparse_row_store_test.sv
// csr_sparse_row_store_test: self-checking bench for the sparse row store; a predictor
// tracks the stored matrix, and every result beat is checked against it. Depends on csr_pkg.
module csr_sparse_row_store_test;
    import csr_pkg::*;

    localparam int ROW_CAP = 256;
    localparam int COL_CAP = 256;
    localparam int NZ_CAP = 4096;
    localparam int IDLE_LIMIT = 4000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_item          i_in;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_item         o_out;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    csr_sparse_row_store dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted matrix contents and counters
    logic [VALUE_W-1:0] nz_value  [NZ_CAP];
    logic [INDEX_W-1:0] nz_column [NZ_CAP];
    logic [COUNT_W-1:0] row_end   [ROW_CAP];
    int unsigned        nz_stored = 0;
    int unsigned        rows_done = 0;
    int unsigned        col_pos = 0;
    int unsigned        cfg_rows = 0;
    int unsigned        cfg_cols = 0;

    t_out_item pending_out [$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        calm = 1'b0;   // no gaps and no stalls while set

    function automatic int unsigned rows_limit();
        return (cfg_rows > ROW_CAP) ? ROW_CAP : cfg_rows;
    endfunction

    function automatic int unsigned cols_limit();
        return (cfg_cols > COL_CAP) ? COL_CAP : cfg_cols;
    endfunction

    function automatic t_status store_append(input logic [VALUE_W-1:0] v);
        int unsigned cols;
        t_status     st;
        cols = cols_limit();
        st = ST_OK;
        if (rows_done >= rows_limit())
            return ST_FULL;
        if (cols != 0) begin
            // both signed zeros are skipped
            if (v[VALUE_W-2:0] != '0) begin
                if (nz_stored >= NZ_CAP) begin
                    st = ST_OVERFLOW;
                end else begin
                    nz_value[nz_stored] = v;
                    nz_column[nz_stored] = INDEX_W'(col_pos);
                    nz_stored++;
                end
            end
            col_pos++;
            if (col_pos < cols)
                return st;
        end
        row_end[rows_done] = COUNT_W'(nz_stored);
        rows_done++;
        col_pos = 0;
        return st;
    endfunction

    function automatic t_status row_lookup(input logic [INDEX_W-1:0] row,
                                           input logic [INDEX_W-1:0] col,
                                           output logic [VALUE_W-1:0] val);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        val = '0;
        if (row >= rows_limit() || col >= cols_limit())
            return ST_RANGE;
        // incomplete rows read as empty
        if (row >= rows_done)
            return ST_OK;
        lo = (row == 0) ? 0 : row_end[row - 1];
        hi = row_end[row];
        while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (nz_column[mid] == col) begin
                val = nz_value[mid];
                return ST_OK;
            end
            if (nz_column[mid] > col)
                hi = mid;
            else
                lo = mid + 1;
        end
        return ST_OK;
    endfunction

    function automatic t_out_item predict_beat(input t_in_item b);
        t_out_item          r;
        logic [VALUE_W-1:0] v;
        v = '0;
        if (b.kind == KIND_APPEND)
            r.status = store_append(b.elem_value);
        else
            r.status = row_lookup(b.row_index, b.col_index, v);
        r.read_value = v;
        r.nonzero_count = COUNT_W'(nz_stored);
        r.rows_filled = ROWS_W'(rows_done);
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0, 1: return 32'h0000_0000;
            2: return 32'h8000_0000;
            3: begin
                case ($urandom_range(0, 3))
                    0: return 32'hFFFF_FFFF;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0001;
                    default: return 32'h8000_0001;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] nonzero_elem();
        logic [VALUE_W-1:0] v;
        v = $urandom;
        if (v[VALUE_W-2:0] == '0)
            v[0] = 1'b1;
        return v;
    endfunction

    function automatic t_in_item append_beat(input logic [VALUE_W-1:0] v);
        t_in_item b;
        b.kind = KIND_APPEND;
        b.elem_value = v;
        b.row_index = INDEX_W'($urandom);
        b.col_index = INDEX_W'($urandom);
        return b;
    endfunction

    function automatic t_in_item read_beat(input logic [INDEX_W-1:0] row,
                                           input logic [INDEX_W-1:0] col);
        t_in_item b;
        b.kind = KIND_READ;
        b.elem_value = $urandom;
        b.row_index = row;
        b.col_index = col;
        return b;
    endfunction

    // read aimed inside the configured shape
    function automatic t_in_item near_read();
        logic [INDEX_W-1:0] row;
        logic [INDEX_W-1:0] col;
        row = (rows_limit() > 0) ? INDEX_W'($urandom_range(0, rows_limit() - 1))
                                 : INDEX_W'($urandom);
        col = (cols_limit() > 0) ? INDEX_W'($urandom_range(0, cols_limit() - 1))
                                 : INDEX_W'($urandom);
        return read_beat(row, col);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    task automatic send_item(input t_in_item b);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= b;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        pending_out.push_back(predict_beat(b));
    endtask

    task automatic cfg_write(input logic idx, input int unsigned value);
        i_in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_NUM_ROWS)
            cfg_rows = value & 32'h1FF;
        else
            cfg_cols = value & 32'h1FF;
        // read back
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[CFG_W-1:0] !== CFG_W'(value))
            flag_mismatch($sformatf("reg %0d read back %0h, wrote %0h", idx,
                                    prdata[CFG_W-1:0], value));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: a fresh stall for every beat
    initial begin
        int stall;
        forever begin
            stall = calm ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do
                @(posedge i_clk);
            while (o_out_valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = o_out;
            if (pending_out.size() == 0) begin
                flag_mismatch("result beat with nothing outstanding");
            end else begin
                want = pending_out.pop_front();
                if (got.read_value !== want.read_value)
                    flag_mismatch($sformatf("read_value %08h, want %08h",
                                            got.read_value, want.read_value));
                if (got.status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d",
                                            got.status, want.status));
                if (got.nonzero_count !== want.nonzero_count)
                    flag_mismatch($sformatf("nonzero_count %0d, want %0d",
                                            got.nonzero_count, want.nonzero_count));
                if (got.rows_filled !== want.rows_filled)
                    flag_mismatch($sformatf("rows_filled %0d, want %0d",
                                            got.rows_filled, want.rows_filled));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_empty_matrix();
        cfg_write(REG_NUM_ROWS, 0);
        cfg_write(REG_NUM_COLS, 0);
        send_item(append_beat(32'h3F80_0000));
        send_item(read_beat(8'd0, 8'd0));
    endtask

    task automatic test_zero_columns();
        cfg_write(REG_NUM_ROWS, 3);
        send_item(append_beat(32'h1234_5678));
    endtask

    task automatic test_row_reads();
        cfg_write(REG_NUM_COLS, 4);
        send_item(append_beat(32'h3F80_0000));
        send_item(append_beat(32'h8000_0000));
        send_item(append_beat(32'h0000_0000));
        send_item(append_beat(32'hFFFF_FFFF));
        for (int c = 0; c < 4; c++)
            send_item(read_beat(8'd1, INDEX_W'(c)));
        send_item(read_beat(8'd0, 8'd0));
        send_item(read_beat(8'd2, 8'd0));
        send_item(read_beat(8'd3, 8'd0));
        send_item(read_beat(8'd0, 8'd4));
        send_item(read_beat(8'd255, 8'd255));
    endtask

    task automatic test_mid_row_change();
        send_item(append_beat(32'h7FFF_FFFF));
        send_item(append_beat(32'h0000_0001));
        // shrink below the current position: next append closes the row
        cfg_write(REG_NUM_COLS, 1);
        send_item(append_beat(32'h8000_0001));
        send_item(read_beat(8'd2, 8'd0));
        send_item(append_beat(32'h4000_0000));
        cfg_write(REG_NUM_COLS, 4);
        send_item(read_beat(8'd2, 8'd2));
        send_item(read_beat(8'd2, 8'd3));
    endtask

    task automatic test_random_phases();
        int unsigned col_plan [8];
        int unsigned rows;
        int          pick;
        col_plan = '{1, 5, 256, 12, 2, 33, 0, 7};
        for (int p = 0; p < 8; p++) begin
            if (col_plan[p] == COL_CAP)
                rows = ROW_CAP;
            else
                rows = rows_done + $urandom_range(1, 12);
            if (rows > ROW_CAP)
                rows = ROW_CAP;
            cfg_write(REG_NUM_ROWS, rows);
            cfg_write(REG_NUM_COLS, col_plan[p]);
            calm = (p == 1 || p == 4);
            for (int i = 0; i < 250; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    send_item(append_beat(rand_elem()));
                else if (pick < 85)
                    send_item(near_read());
                else
                    send_item(read_beat(INDEX_W'($urandom), INDEX_W'($urandom)));
            end
        end
        calm = 1'b0;
    endtask

    task automatic test_store_overflow();
        cfg_write(REG_NUM_ROWS, ROW_CAP);
        cfg_write(REG_NUM_COLS, COL_CAP);
        calm = 1'b1;
        while (nz_stored < NZ_CAP && rows_done < ROW_CAP) begin
            if ($urandom_range(0, 9) == 0)
                send_item(near_read());
            else
                send_item(append_beat(nonzero_elem()));
        end
        calm = 1'b0;
        for (int i = 0; i < 80; i++) begin
            if ($urandom_range(0, 1) == 0)
                send_item(append_beat(rand_elem()));
            else
                send_item(near_read());
        end
    endtask

    task automatic test_fill_rows();
        cfg_write(REG_NUM_COLS, 1);
        while (rows_done < ROW_CAP) begin
            if ($urandom_range(0, 4) == 0)
                send_item(near_read());
            else
                send_item(append_beat(rand_elem()));
        end
        repeat (5) send_item(append_beat(rand_elem()));
        cfg_write(REG_NUM_COLS, COL_CAP);
        send_item(read_beat(8'd255, 8'd255));
        repeat (80) send_item(near_read());
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_matrix();
        test_zero_columns();
        test_row_reads();
        test_mid_row_change();
        test_random_phases();
        test_store_overflow();
        test_fill_rows();
        i_in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### csr_sparse_row_store.f
src/csr_pkg.sv
src/csr_nz_mem.sv
src/csr_rp_mem.sv
src/csr_engine.sv
src/csr_sparse_row_store.sv
tb/sv/csr_sparse_row_store_test.sv
